/* design/bmwb_pkg.sv */
package bmwb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PROD_SHIFT = 16;
  localparam int DATA_W     = 32;
  localparam int WALL_W     = 31;
  localparam int BOUNCE_W   = 17;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int OPA_W      = DATA_W + 1;
  localparam int OPB_W      = BOUNCE_W + 1;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int SCALED_W   = PROD_W - PROD_SHIFT;
  localparam int SUM_W      = SCALED_W + 1;

  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;

  localparam logic signed [DATA_W-1:0] ACCEL_X_RST = '0;
  localparam logic signed [DATA_W-1:0] ACCEL_Y_RST = DATA_W'(-((981 * ONE_L + 50) / 100));
  localparam logic [WALL_W-1:0]        WALL_X_RST  = WALL_W'(5 * ONE_L);
  localparam logic [WALL_W-1:0]        WALL_Y_RST  = WALL_W'((15 * ONE_L) / 4);
  localparam logic [WALL_W-1:0]        HALF_RST    = WALL_W'(ONE_L / 4);
  localparam logic [BOUNCE_W-1:0]      BOUNCE_RST  = BOUNCE_W'(6554);
  localparam logic signed [DATA_W-1:0] VEL_X_RST   = DATA_W'(20 * ONE_L);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_X     = 3'd0,
    REG_ACCEL_Y     = 3'd1,
    REG_WALL_X      = 3'd2,
    REG_WALL_Y      = 3'd3,
    REG_HALF_WIDTH  = 3'd4,
    REG_HALF_HEIGHT = 3'd5,
    REG_BOUNCE      = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAX, S_MAY, S_MVX, S_MVY, S_APY,
    S_XH, S_XH_R, S_XL, S_XL_R, S_YH, S_YH_R, S_YL, S_YL_R, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_AX, MUL_AY, MUL_VX, MUL_VY, MUL_NVX, MUL_NVY
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_VX, ACC_VY, ACC_PX, ACC_PY, ACC_RVX, ACC_RVY
  } acc_op_t;

  typedef enum logic [2:0] {
    CHK_NONE, CHK_XH, CHK_XL, CHK_YH, CHK_YL
  } chk_op_t;

  typedef struct packed {
    logic    load_dt;
    mul_op_t mul;
    acc_op_t acc;
    chk_op_t chk;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/bmwb_ctrl.sv */
module bmwb_ctrl
  import bmwb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.load_dt  = 1'b0;
    cmd.mul      = MUL_NONE;
    cmd.acc      = ACC_NONE;
    cmd.chk      = CHK_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_dt = 1'b1;
          state_nxt   = S_MAX;
        end
      end
      S_MAX: begin
        cmd.mul   = MUL_AX;
        state_nxt = S_MAY;
      end
      S_MAY: begin
        cmd.mul   = MUL_AY;
        cmd.acc   = ACC_VX;
        state_nxt = S_MVX;
      end
      S_MVX: begin
        cmd.mul   = MUL_VX;
        cmd.acc   = ACC_VY;
        state_nxt = S_MVY;
      end
      S_MVY: begin
        cmd.mul   = MUL_VY;
        cmd.acc   = ACC_PX;
        state_nxt = S_APY;
      end
      S_APY: begin
        cmd.acc   = ACC_PY;
        state_nxt = S_XH;
      end
      S_XH: begin
        cmd.chk   = CHK_XH;
        cmd.mul   = MUL_NVX;
        state_nxt = status.hit ? S_XH_R : S_XL;
      end
      S_XH_R: begin
        cmd.acc   = ACC_RVX;
        state_nxt = S_XL;
      end
      S_XL: begin
        cmd.chk   = CHK_XL;
        cmd.mul   = MUL_NVX;
        state_nxt = status.hit ? S_XL_R : S_YH;
      end
      S_XL_R: begin
        cmd.acc   = ACC_RVX;
        state_nxt = S_YH;
      end
      S_YH: begin
        cmd.chk   = CHK_YH;
        cmd.mul   = MUL_NVY;
        state_nxt = status.hit ? S_YH_R : S_YL;
      end
      S_YH_R: begin
        cmd.acc   = ACC_RVY;
        state_nxt = S_YL;
      end
      S_YL: begin
        cmd.chk   = CHK_YL;
        cmd.mul   = MUL_NVY;
        state_nxt = status.hit ? S_YL_R : S_OUT;
      end
      S_YL_R: begin
        cmd.acc   = ACC_RVY;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/bmwb_dp.sv */
module bmwb_dp
  import bmwb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic [STEP_W-1:0]        in_step_time,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic signed [DATA_W-1:0] out_pos_x_out,
  output logic signed [DATA_W-1:0] out_pos_y_out,
  output logic signed [DATA_W-1:0] out_vel_x_out,
  output logic signed [DATA_W-1:0] out_vel_y_out
);

  logic signed [DATA_W-1:0] accel_x_r, accel_y_r;
  logic [WALL_W-1:0]        wall_x_r, wall_y_r, half_w_r, half_h_r;
  logic [BOUNCE_W-1:0]      bounce_r;

  logic signed [DATA_W-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [DATA_W-1:0] pos_x_nxt, pos_y_nxt, vel_x_nxt, vel_y_nxt;
  logic [STEP_W-1:0]        dt_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [DATA_W-1:0] out_px_r, out_py_r, out_vx_r, out_vy_r;

  logic signed [OPA_W-1:0]    mul_a;
  logic signed [OPB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]    acc_base;
  logic signed [DATA_W-1:0]   acc_sum, refl_val;

  logic signed [DATA_W-1:0] chk_p;
  logic [WALL_W-1:0]        chk_wall, chk_half;
  logic signed [OPA_W-1:0]  chk_p_ext, lim_hi, lim_lo, lim_sel;
  logic                     chk_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_x_r <= ACCEL_X_RST;
      accel_y_r <= ACCEL_Y_RST;
      wall_x_r  <= WALL_X_RST;
      wall_y_r  <= WALL_Y_RST;
      half_w_r  <= HALF_RST;
      half_h_r  <= HALF_RST;
      bounce_r  <= BOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_X:     accel_x_r <= cfg_data;
        REG_ACCEL_Y:     accel_y_r <= cfg_data;
        REG_WALL_X:      wall_x_r  <= cfg_data[WALL_W-1:0];
        REG_WALL_Y:      wall_y_r  <= cfg_data[WALL_W-1:0];
        REG_HALF_WIDTH:  half_w_r  <= cfg_data[WALL_W-1:0];
        REG_HALF_HEIGHT: half_h_r  <= cfg_data[WALL_W-1:0];
        REG_BOUNCE:      bounce_r  <= cfg_data[BOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul)
      MUL_AX:  mul_a = OPA_W'(accel_x_r);
      MUL_AY:  mul_a = OPA_W'(accel_y_r);
      MUL_VX:  mul_a = OPA_W'(vel_x_r);
      MUL_VY:  mul_a = OPA_W'(vel_y_r);
      MUL_NVX: mul_a = -OPA_W'(vel_x_r);
      MUL_NVY: mul_a = -OPA_W'(vel_y_r);
      default: mul_a = '0;
    endcase
    case (cmd.mul)
      MUL_NVX, MUL_NVY: mul_b = $signed({1'b0, bounce_r});
      default:          mul_b = $signed({{(OPB_W-STEP_W){1'b0}}, dt_r});
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dt) begin
      dt_r <= in_step_time;
    end
    if (cmd.mul != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
  end

  assign scaled = prod_r[PROD_W-1:PROD_SHIFT];

  always_comb begin
    case (cmd.acc)
      ACC_VX:  acc_base = SUM_W'(vel_x_r);
      ACC_VY:  acc_base = SUM_W'(vel_y_r);
      ACC_PX:  acc_base = SUM_W'(pos_x_r);
      ACC_PY:  acc_base = SUM_W'(pos_y_r);
      default: acc_base = '0;
    endcase
    acc_sum  = sat32(acc_base + SUM_W'(scaled));
    refl_val = sat32(SUM_W'(scaled));
  end

  always_comb begin
    case (cmd.chk)
      CHK_XH, CHK_XL: begin
        chk_p    = pos_x_r;
        chk_wall = wall_x_r;
        chk_half = half_w_r;
      end
      default: begin
        chk_p    = pos_y_r;
        chk_wall = wall_y_r;
        chk_half = half_h_r;
      end
    endcase
    chk_p_ext = OPA_W'(chk_p);
    lim_hi    = $signed({2'b00, chk_wall}) - $signed({2'b00, chk_half});
    lim_lo    = -lim_hi;
    case (cmd.chk)
      CHK_XH, CHK_YH: begin
        chk_hit = (chk_p_ext >= lim_hi);
        lim_sel = lim_hi;
      end
      CHK_XL, CHK_YL: begin
        chk_hit = (chk_p_ext <= lim_lo);
        lim_sel = lim_lo;
      end
      default: begin
        chk_hit = 1'b0;
        lim_sel = lim_hi;
      end
    endcase
  end

  assign status.hit = chk_hit;

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    case (cmd.acc)
      ACC_VX:  vel_x_nxt = acc_sum;
      ACC_VY:  vel_y_nxt = acc_sum;
      ACC_PX:  pos_x_nxt = acc_sum;
      ACC_PY:  pos_y_nxt = acc_sum;
      ACC_RVX: vel_x_nxt = refl_val;
      ACC_RVY: vel_y_nxt = refl_val;
      default: ;
    endcase
    if (chk_hit) begin
      case (cmd.chk)
        CHK_XH, CHK_XL: pos_x_nxt = lim_sel[DATA_W-1:0];
        CHK_YH, CHK_YL: pos_y_nxt = lim_sel[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= VEL_X_RST;
      vel_y_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_px_r <= pos_x_r;
      out_py_r <= pos_y_r;
      out_vx_r <= vel_x_r;
      out_vy_r <= vel_y_r;
    end
  end

  assign out_pos_x_out = out_px_r;
  assign out_pos_y_out = out_py_r;
  assign out_vel_x_out = out_vx_r;
  assign out_vel_y_out = out_vy_r;

endmodule

/* design/box_motion_wall_bounce_top.sv */
// Channel  Handshake               Payload
// in       in_valid / in_stall     in_step_time
// out      out_valid / out_stall   out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An accepted item runs through five integration steps sharing one
// 33x18 multiplier, four wall checks that each add a restitution write-back state
// when they fire, and an output load; no new item is accepted until that load is done.
// Reset is synchronous, active low; registers and motion state load their defaults.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in its last step until that register frees. cfg_ready is always high.
module box_motion_wall_bounce_top
  import bmwb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [STEP_W-1:0]        in_step_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_pos_x_out,
  output logic signed [DATA_W-1:0] out_pos_y_out,
  output logic signed [DATA_W-1:0] out_vel_x_out,
  output logic signed [DATA_W-1:0] out_vel_y_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bmwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bmwb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_step_time  (in_step_time),
    .cmd           (cmd),
    .status        (status),
    .out_pos_x_out (out_pos_x_out),
    .out_pos_y_out (out_pos_y_out),
    .out_vel_x_out (out_vel_x_out),
    .out_vel_y_out (out_vel_y_out)
  );

endmodule
